// ----- rtl/wrtcid_pkg.sv -----
package wrtcid_pkg;

  // Field widths
  localparam int IDX_W    = 20;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 4;
  localparam int LEVEL_W  = 3;
  localparam int SYM_W    = 7;

  // Width of the index arithmetic: wide enough for the largest level-four
  // product at the largest allowed level sizes.
  localparam int WIDE_W = 28;

  // Codeword level sizes
  localparam int LEVEL1_SIZE = 64;
  localparam int LEVEL2_SIZE = 32;
  localparam int LEVEL3_SIZE = 16;

  localparam logic [WIDE_W-1:0] L1    = WIDE_W'(LEVEL1_SIZE);
  localparam logic [WIDE_W-1:0] P12   = WIDE_W'(LEVEL1_SIZE + LEVEL2_SIZE);
  localparam logic [WIDE_W-1:0] P123  = WIDE_W'(LEVEL1_SIZE + LEVEL2_SIZE + LEVEL3_SIZE);
  localparam logic [WIDE_W-1:0] S12   = WIDE_W'(LEVEL1_SIZE * LEVEL2_SIZE);
  localparam logic [WIDE_W-1:0] S123  = WIDE_W'(LEVEL1_SIZE * LEVEL2_SIZE * LEVEL3_SIZE);
  localparam logic [WIDE_W-1:0] BASE3 = WIDE_W'(LEVEL1_SIZE * LEVEL2_SIZE + LEVEL1_SIZE);
  localparam logic [WIDE_W-1:0] BASE4 = WIDE_W'(LEVEL1_SIZE * LEVEL2_SIZE * LEVEL3_SIZE
                                               + LEVEL1_SIZE * LEVEL2_SIZE + LEVEL1_SIZE);
  localparam logic [WIDE_W-1:0] IDX_MAX = WIDE_W'(20'hFFFFF);

  // Control bytes of the stream
  localparam logic [BYTE_W-1:0] FIRST_UPPER_BYTE = 8'd1;
  localparam logic [BYTE_W-1:0] UPPER_WORD_BYTE  = 8'd2;
  localparam logic [BYTE_W-1:0] ESC_BYTE         = 8'd3;
  localparam logic [BYTE_W-1:0] UTF_UPPER_BYTE   = 8'd4;

  // Decoder level codes
  localparam logic [LEVEL_W-1:0] LVL_IDLE  = 3'd0;
  localparam logic [LEVEL_W-1:0] LVL_ONE   = 3'd1;
  localparam logic [LEVEL_W-1:0] LVL_TWO   = 3'd2;
  localparam logic [LEVEL_W-1:0] LVL_THREE = 3'd3;
  localparam logic [LEVEL_W-1:0] LVL_ESC   = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_PASS        = 4'd0;
  localparam logic [STATUS_W-1:0] ST_WAIT2       = 4'd1;
  localparam logic [STATUS_W-1:0] ST_WAIT3       = 4'd2;
  localparam logic [STATUS_W-1:0] ST_WAIT4       = 4'd3;
  localparam logic [STATUS_W-1:0] ST_WORD        = 4'd4;
  localparam logic [STATUS_W-1:0] ST_FIRST_UPPER = 4'd5;
  localparam logic [STATUS_W-1:0] ST_UPPER_WORD  = 4'd6;
  localparam logic [STATUS_W-1:0] ST_ESCAPED     = 4'd7;
  localparam logic [STATUS_W-1:0] ST_UTF_UPPER   = 4'd8;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX   = 4'd9;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [IDX_W-1:0]   partial;
    logic               corrupt;
  } state_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    word_number;
    logic [BYTE_W-1:0]   out_byte;
  } result_t;

endpackage

// ----- rtl/wrtcid_step.sv -----
module wrtcid_step (
  input  logic [wrtcid_pkg::BYTE_W-1:0] in_byte_i,
  input  logic [wrtcid_pkg::IDX_W-1:0]  dict_size_i,
  input  wrtcid_pkg::state_t            state_i,
  output wrtcid_pkg::state_t            state_o,
  output wrtcid_pkg::result_t           result_o
);

  localparam int WW = wrtcid_pkg::WIDE_W;

  function automatic logic [wrtcid_pkg::IDX_W-1:0] clamp_idx(input logic [WW-1:0] v);
    clamp_idx = (v > wrtcid_pkg::IDX_MAX) ? wrtcid_pkg::IDX_MAX[wrtcid_pkg::IDX_W-1:0]
                                          : v[wrtcid_pkg::IDX_W-1:0];
  endfunction

  logic [wrtcid_pkg::SYM_W-1:0] sym;
  logic [WW-1:0] sym_w;
  logic [WW-1:0] d_w;
  logic          lt_l1;
  logic          lt_p12;
  logic          lt_p123;
  logic [WW-1:0] prod_a;
  logic [WW-1:0] prod_b;
  logic [WW-1:0] prod_c;
  logic          do_finish;
  logic [WW-1:0] fin_idx;

  // Non-symbol bytes count as symbol zero
  assign sym     = in_byte_i[7] ? in_byte_i[wrtcid_pkg::SYM_W-1:0] : '0;
  assign sym_w   = WW'(sym);
  assign d_w     = WW'(state_i.partial);
  assign lt_l1   = sym_w < wrtcid_pkg::L1;
  assign lt_p12  = sym_w < wrtcid_pkg::P12;
  assign lt_p123 = sym_w < wrtcid_pkg::P123;

  // Constant multiplies; only the one picked by the range compares is used
  assign prod_a = wrtcid_pkg::L1   * (sym_w - wrtcid_pkg::L1);
  assign prod_b = wrtcid_pkg::S12  * (sym_w - wrtcid_pkg::P12);
  assign prod_c = wrtcid_pkg::S123 * (sym_w - wrtcid_pkg::P123);

  always_comb begin
    state_o   = state_i;
    result_o  = '0;
    do_finish = 1'b0;
    fin_idx   = '0;

    unique case (state_i.level)
      wrtcid_pkg::LVL_ESC: begin
        state_o.level     = wrtcid_pkg::LVL_IDLE;
        state_o.partial   = '0;
        result_o.status   = wrtcid_pkg::ST_ESCAPED;
        result_o.out_byte = in_byte_i;
      end
      wrtcid_pkg::LVL_ONE: begin
        if (lt_l1) begin
          do_finish = 1'b1;
          fin_idx   = d_w + sym_w + wrtcid_pkg::L1;
        end else begin
          state_o.partial = clamp_idx(lt_p12 ? (d_w + prod_a) : (d_w + prod_b));
          state_o.level   = wrtcid_pkg::LVL_TWO;
          result_o.status = wrtcid_pkg::ST_WAIT3;
        end
      end
      wrtcid_pkg::LVL_TWO: begin
        if (lt_l1) begin
          do_finish = 1'b1;
          fin_idx   = d_w + sym_w + wrtcid_pkg::BASE3;
        end else begin
          state_o.partial = clamp_idx(lt_p12 ? (d_w + prod_a) : d_w);
          state_o.level   = wrtcid_pkg::LVL_THREE;
          result_o.status = wrtcid_pkg::ST_WAIT4;
        end
      end
      wrtcid_pkg::LVL_THREE: begin
        do_finish = 1'b1;
        fin_idx   = d_w + (lt_l1 ? sym_w : '0) + wrtcid_pkg::BASE4;
      end
      default: begin
        // Idle; unused level codes behave as idle too
        state_o.level = wrtcid_pkg::LVL_IDLE;
        if (state_i.corrupt) begin
          result_o.out_byte = in_byte_i;
        end else if (in_byte_i == wrtcid_pkg::ESC_BYTE) begin
          state_o.level   = wrtcid_pkg::LVL_ESC;
          state_o.partial = '0;
        end else if (in_byte_i == wrtcid_pkg::FIRST_UPPER_BYTE) begin
          state_o.partial = '0;
          result_o.status = wrtcid_pkg::ST_FIRST_UPPER;
        end else if (in_byte_i == wrtcid_pkg::UPPER_WORD_BYTE) begin
          state_o.partial = '0;
          result_o.status = wrtcid_pkg::ST_UPPER_WORD;
        end else if (in_byte_i == wrtcid_pkg::UTF_UPPER_BYTE) begin
          state_o.partial = '0;
          result_o.status = wrtcid_pkg::ST_UTF_UPPER;
        end else if (in_byte_i[7]) begin
          if (lt_l1) begin
            do_finish = 1'b1;
            fin_idx   = sym_w;
          end else begin
            state_o.partial = clamp_idx(lt_p12 ? prod_a : (lt_p123 ? prod_b : prod_c));
            state_o.level   = wrtcid_pkg::LVL_ONE;
            result_o.status = wrtcid_pkg::ST_WAIT2;
          end
        end else begin
          state_o.partial   = '0;
          result_o.out_byte = in_byte_i;
        end
      end
    endcase

    // Close the codeword and range-check the entry number
    if (do_finish) begin
      state_o.level   = wrtcid_pkg::LVL_IDLE;
      state_o.partial = '0;
      if (fin_idx < WW'(dict_size_i)) begin
        result_o.status      = wrtcid_pkg::ST_WORD;
        result_o.word_number = fin_idx[wrtcid_pkg::IDX_W-1:0] + wrtcid_pkg::IDX_W'(1);
      end else begin
        state_o.corrupt = 1'b1;
        result_o.status = wrtcid_pkg::ST_BAD_INDEX;
      end
    end
  end

endmodule

// ----- rtl/wrt_codeword_index_decoder_top.sv -----
// Codeword index decoder for a word-replaced text stream. Each input beat is
// one stream byte; each byte yields exactly one result beat carrying a status,
// a 1-based dictionary entry number (for status word) and an echoed byte (for
// pass-through and escaped bytes). Bytes 128..255 are codeword symbols that
// build the entry number over up to four bytes; bytes 1, 2 and 4 are case
// flags, byte 3 escapes the following byte, and an entry number above the
// dictionary size reports a bad index and sets a sticky corrupt flag that
// makes later idle bytes pass through until reset. The block takes one byte
// per cycle while its results are taken: an input register feeds a
// single-pass decode (range compares, one constant multiply-add and the
// dictionary size compare), whose outcome lands in the result register while
// the decoder state advances in the same cycle. The result register lets a new
// byte enter while the previous result waits for out_ready_i. Write the
// dictionary size only while no beat is in flight.
module wrt_codeword_index_decoder_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [wrtcid_pkg::BYTE_W-1:0]     in_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [wrtcid_pkg::STATUS_W-1:0]   status_o,
  output logic [wrtcid_pkg::IDX_W-1:0]      word_number_o,
  output logic [wrtcid_pkg::BYTE_W-1:0]     out_byte_o,
  input  logic                              dict_size_we_i,
  input  logic [wrtcid_pkg::IDX_W-1:0]      dict_size_i
);

  logic                          in_valid_q;
  logic [wrtcid_pkg::BYTE_W-1:0] in_byte_q;
  logic                          out_valid_q;
  wrtcid_pkg::result_t           result_q;
  wrtcid_pkg::result_t           step_res;
  wrtcid_pkg::state_t            state_q;
  wrtcid_pkg::state_t            state_d;
  logic [wrtcid_pkg::IDX_W-1:0]  dict_size_q;
  logic                          out_adv;
  logic                          step_adv;

  // Result register frees up when empty or being taken this cycle
  assign out_adv    = !out_valid_q || out_ready_i;
  // Decode the buffered byte when its result has somewhere to go
  assign step_adv   = in_valid_q && out_adv;
  assign in_ready_o = !in_valid_q || out_adv;

  wrtcid_step u_step (
    .in_byte_i   (in_byte_q),
    .dict_size_i (dict_size_q),
    .state_i     (state_q),
    .state_o     (state_d),
    .result_o    (step_res)
  );

  // Control: beat valids, decoder state and the dictionary size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
      dict_size_q <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
      // Advance decoder state only as a byte is consumed
      if (step_adv) begin
        state_q <= state_d;
      end
      if (dict_size_we_i) begin
        dict_size_q <= dict_size_i;
      end
    end
  end

  // Payload: capture the incoming byte and hold the result while stalled
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
    end
    if (step_adv) begin
      result_q <= step_res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = result_q.status;
  assign word_number_o = result_q.word_number;
  assign out_byte_o    = result_q.out_byte;

`ifndef NO_ASSERTIONS
  // A bad index must raise the corrupt flag
  a_bad_sets_corrupt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_adv && step_res.status == wrtcid_pkg::ST_BAD_INDEX) |=> state_q.corrupt)
    else $error("bad index did not set corrupt flag");

  // The corrupt flag clears only on reset
  a_corrupt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.corrupt |=> state_q.corrupt)
    else $error("corrupt flag cleared without reset");

  // Entry number is zero unless a word is reported
  a_number_only_on_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_o != wrtcid_pkg::ST_WORD) |-> (word_number_o == '0))
    else $error("word number set on non-word result");

  // A reported word lies within the loaded dictionary
  a_word_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_adv && step_res.status == wrtcid_pkg::ST_WORD) |->
      (step_res.word_number != '0 && step_res.word_number <= dict_size_q))
    else $error("word number out of range");
`endif

endmodule
